// ===== rtl/pvrf_pkg.sv =====
package pvrf_pkg;

   localparam int DefPatchEdge = 8;
   localparam int CoordW       = 3;
   localparam int CompW        = 24;
   localparam int CellW        = 3 * CompW;
   localparam int ThrW         = 16;
   localparam int CoordCmpW    = 6;
   localparam int StepW        = 4;

   // read slots: centre, then plus and minus neighbour along x, y, z
   localparam logic [StepW-1:0] SlotCentre = 4'd0;
   localparam logic [StepW-1:0] SlotXp     = 4'd1;
   localparam logic [StepW-1:0] SlotXm     = 4'd2;
   localparam logic [StepW-1:0] SlotYp     = 4'd3;
   localparam logic [StepW-1:0] SlotYm     = 4'd4;
   localparam logic [StepW-1:0] SlotZp     = 4'd5;
   localparam logic [StepW-1:0] SlotZm     = 4'd6;
   localparam logic [StepW-1:0] ReadLast   = 4'd7;

   // multiplier slots
   localparam logic [StepW-1:0] MulVx    = 4'd0;
   localparam logic [StepW-1:0] MulVy    = 4'd1;
   localparam logic [StepW-1:0] MulVz    = 4'd2;
   localparam logic [StepW-1:0] MulWx    = 4'd3;
   localparam logic [StepW-1:0] MulWy    = 4'd4;
   localparam logic [StepW-1:0] MulWz    = 4'd5;
   localparam logic [StepW-1:0] MulThr   = 4'd6;
   localparam logic [StepW-1:0] MulRhsLo = 4'd7;
   localparam logic [StepW-1:0] MulRhsHi = 4'd8;
   localparam logic [StepW-1:0] MulLast  = 4'd9;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_CMP,
      S_DONE
   } state_type;

endpackage

// ===== rtl/pvrf_store.sv =====
module pvrf_store #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [pvrf_pkg::CellW-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [pvrf_pkg::CellW-1:0] rd_data
);
   import pvrf_pkg::*;

   logic [CellW-1:0] mem [DEPTH];
   logic [CellW-1:0] rd_data_ff;

   // write one cell word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/patch_vorticity_refine_flag.sv =====
// Holds one cubic patch of PATCH_EDGE^3 three-component vectors and answers
// per-cell vorticity refinement queries. A load word (mode 0) writes one cell
// and gives no result. A query word (mode 1) gives its flag after eight read
// steps of the single patch memory port (centre and six neighbours, then the
// last read data), ten steps of the one shared 32x32 multiplier (squared
// magnitude, squared curl, squared threshold, two partial products of the right
// side, then the last fold), one compare step and a done step that hands over
// the flag; the next word is taken once the block is back in idle. req_stall
// stays high from an accepted query until then, and for as long as a stalled
// flag still holds the output register; a finished flag waits in the output
// register while the next word is taken. A query outside the patch answers 0.
// Cells read by a query must have been written since reset.
module patch_vorticity_refine_flag #(
   parameter int PATCH_EDGE = pvrf_pkg::DefPatchEdge
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_mode,
   input  logic [pvrf_pkg::CoordW-1:0]  req_cell_x,
   input  logic [pvrf_pkg::CoordW-1:0]  req_cell_y,
   input  logic [pvrf_pkg::CoordW-1:0]  req_cell_z,
   input  logic signed [pvrf_pkg::CompW-1:0] req_comp_x,
   input  logic signed [pvrf_pkg::CompW-1:0] req_comp_y,
   input  logic signed [pvrf_pkg::CompW-1:0] req_comp_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_refine_flag,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pvrf_pkg::ThrW-1:0]    csr_curl_threshold
);
   import pvrf_pkg::*;

   localparam int IW    = $clog2(PATCH_EDGE);
   localparam int DEPTH = PATCH_EDGE * PATCH_EDGE * PATCH_EDGE;
   localparam int AW    = $clog2(DEPTH);

   function automatic logic [IW-1:0] to_idx(input logic [CoordW-1:0] c);
      return IW'(c);
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] x,
                                               input logic [IW-1:0] y,
                                               input logic [IW-1:0] z);
      return AW'((int'(z) * PATCH_EDGE + int'(y)) * PATCH_EDGE + int'(x));
   endfunction

   function automatic logic [IW-1:0] nb_plus(input logic [IW-1:0] c);
      if (c == '0) return IW'(1);
      else if (c == IW'(PATCH_EDGE - 1)) return IW'(PATCH_EDGE - 1);
      else return c + IW'(1);
   endfunction

   function automatic logic [IW-1:0] nb_minus(input logic [IW-1:0] c);
      if (c == '0) return '0;
      else if (c == IW'(PATCH_EDGE - 1)) return IW'(PATCH_EDGE - 2);
      else return c - IW'(1);
   endfunction

   function automatic logic on_face(input logic [IW-1:0] c);
      return (c == '0) || (c == IW'(PATCH_EDGE - 1));
   endfunction

   // weight a difference: double at a face
   function automatic logic signed [26:0] weigh(input logic signed [24:0] d,
                                                input logic f);
      logic signed [26:0] e;
      e = 27'(d);
      return f ? (e <<< 1) : e;
   endfunction

   function automatic logic [31:0] mag(input logic signed [26:0] v);
      logic signed [26:0] a;
      a = v[26] ? -v : v;
      return 32'(unsigned'(a));
   endfunction

   state_type state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;

   logic [ThrW-1:0]  thr_ff;
   logic [IW-1:0]    cx_ff, cy_ff, cz_ff;
   logic             fx_ff, fy_ff, fz_ff;
   logic signed [CompW-1:0] cvx_ff, cvy_ff, cvz_ff;
   logic signed [24:0] dzx_ff, dyx_ff, dzy_ff, dxy_ff, dyz_ff, dxz_ff;
   logic [63:0]      prod_ff;
   logic [49:0]      v2_ff;
   logic [55:0]      w2_ff;
   logic [31:0]      t2_ff;
   logic [81:0]      rhs_ff;
   logic             flag_ff;
   logic             rsp_valid_ff;
   logic             rsp_flag_ff;

   logic             accept;
   logic             in_patch;
   logic             wr_en;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [CellW-1:0] rd_data;
   logic             load_rsp;
   logic [StepW-1:0] slot;
   logic signed [CompW-1:0] rx, ry, rz;
   logic signed [26:0] wx, wy, wz;
   logic [31:0]      mul_a, mul_b;

   assign accept   = req_valid && !req_stall;
   assign in_patch = (CoordCmpW'(req_cell_x) < CoordCmpW'(PATCH_EDGE)) &&
                     (CoordCmpW'(req_cell_y) < CoordCmpW'(PATCH_EDGE)) &&
                     (CoordCmpW'(req_cell_z) < CoordCmpW'(PATCH_EDGE));
   assign wr_en    = accept && !req_mode && in_patch;

   pvrf_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cell_addr(to_idx(req_cell_x), to_idx(req_cell_y), to_idx(req_cell_z))),
      .wr_data ({req_comp_x, req_comp_y, req_comp_z}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // pick the cell for this read slot
   always_comb begin
      case (step_ff)
         SlotXp:  rd_addr = cell_addr(nb_plus(cx_ff), cy_ff, cz_ff);
         SlotXm:  rd_addr = cell_addr(nb_minus(cx_ff), cy_ff, cz_ff);
         SlotYp:  rd_addr = cell_addr(cx_ff, nb_plus(cy_ff), cz_ff);
         SlotYm:  rd_addr = cell_addr(cx_ff, nb_minus(cy_ff), cz_ff);
         SlotZp:  rd_addr = cell_addr(cx_ff, cy_ff, nb_plus(cz_ff));
         SlotZm:  rd_addr = cell_addr(cx_ff, cy_ff, nb_minus(cz_ff));
         default: rd_addr = cell_addr(cx_ff, cy_ff, cz_ff);
      endcase
   end

   assign slot = step_ff - StepW'(1);
   assign rx   = rd_data[3*CompW-1:2*CompW];
   assign ry   = rd_data[2*CompW-1:CompW];
   assign rz   = rd_data[CompW-1:0];

   // curl components from the weighted differences
   assign wx = weigh(dzy_ff, fy_ff) - weigh(dyz_ff, fz_ff);
   assign wy = weigh(dxz_ff, fz_ff) - weigh(dzx_ff, fx_ff);
   assign wz = weigh(dyx_ff, fx_ff) - weigh(dxy_ff, fy_ff);

   // operands of the shared multiplier
   always_comb begin
      case (step_ff)
         MulVx: begin mul_a = mag(27'(cvx_ff)); mul_b = mag(27'(cvx_ff)); end
         MulVy: begin mul_a = mag(27'(cvy_ff)); mul_b = mag(27'(cvy_ff)); end
         MulVz: begin mul_a = mag(27'(cvz_ff)); mul_b = mag(27'(cvz_ff)); end
         MulWx: begin mul_a = mag(wx); mul_b = mag(wx); end
         MulWy: begin mul_a = mag(wy); mul_b = mag(wy); end
         MulWz: begin mul_a = mag(wz); mul_b = mag(wz); end
         MulThr: begin mul_a = 32'(thr_ff); mul_b = 32'(thr_ff); end
         MulRhsLo: begin mul_a = prod_ff[31:0]; mul_b = 32'(v2_ff[23:0]); end
         MulRhsHi: begin mul_a = t2_ff; mul_b = 32'(v2_ff[49:24]); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (accept && req_mode) state_in = in_patch ? S_READ : S_DONE;
         end
         S_READ: begin
            if (step_ff == ReadLast) begin
               state_in = S_MUL;
               step_in  = '0;
            end else begin
               step_in = step_ff + StepW'(1);
            end
         end
         S_MUL: begin
            if (step_ff == MulLast) begin
               state_in = S_CMP;
               step_in  = '0;
            end else begin
               step_in = step_ff + StepW'(1);
            end
         end
         S_CMP:  state_in = S_DONE;
         S_DONE: if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         S_IDLE: req_stall = 1'b0;
         S_READ: rd_en = (step_ff != ReadLast);
         S_DONE: load_rsp = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_valid && csr_ready) thr_ff <= csr_curl_threshold;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && accept) begin
         cx_ff   <= to_idx(req_cell_x);
         cy_ff   <= to_idx(req_cell_y);
         cz_ff   <= to_idx(req_cell_z);
         fx_ff   <= on_face(to_idx(req_cell_x));
         fy_ff   <= on_face(to_idx(req_cell_y));
         fz_ff   <= on_face(to_idx(req_cell_z));
         flag_ff <= 1'b0;
      end
      // gather the centre and the differences one read at a time
      if (state_ff == S_READ && step_ff != SlotCentre) begin
         case (slot)
            SlotCentre: begin cvx_ff <= rx; cvy_ff <= ry; cvz_ff <= rz; end
            SlotXp: begin dzx_ff <= 25'(rz); dyx_ff <= 25'(ry); end
            SlotXm: begin dzx_ff <= dzx_ff - 25'(rz); dyx_ff <= dyx_ff - 25'(ry); end
            SlotYp: begin dzy_ff <= 25'(rz); dxy_ff <= 25'(rx); end
            SlotYm: begin dzy_ff <= dzy_ff - 25'(rz); dxy_ff <= dxy_ff - 25'(rx); end
            SlotZp: begin dyz_ff <= 25'(ry); dxz_ff <= 25'(rx); end
            SlotZm: begin dyz_ff <= dyz_ff - 25'(ry); dxz_ff <= dxz_ff - 25'(rx); end
            default: ;
         endcase
      end
      // multiply, then fold the previous product
      if (state_ff == S_MUL) begin
         prod_ff <= mul_a * mul_b;
         case (step_ff)
            MulVy:    v2_ff  <= 50'(prod_ff[47:0]);
            MulVz:    v2_ff  <= v2_ff + 50'(prod_ff[47:0]);
            MulWx:    v2_ff  <= v2_ff + 50'(prod_ff[47:0]);
            MulWy:    w2_ff  <= 56'(prod_ff[53:0]);
            MulWz:    w2_ff  <= w2_ff + 56'(prod_ff[53:0]);
            MulThr:   w2_ff  <= w2_ff + 56'(prod_ff[53:0]);
            MulRhsLo: t2_ff  <= prod_ff[31:0];
            MulRhsHi: rhs_ff <= 82'(prod_ff[55:0]);
            MulLast:  rhs_ff <= rhs_ff + (82'(prod_ff[57:0]) << 24);
            default: ;
         endcase
      end
      if (state_ff == S_CMP) begin
         flag_ff <= {4'b0, w2_ff, 22'b0} > rhs_ff;
      end
      if (load_rsp) rsp_flag_ff <= flag_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_refine_flag = rsp_flag_ff;
   assign csr_ready       = 1'b1;

   // a query leaves idle, a load stays there
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode |=> state_ff != S_IDLE)
      else $error("query did not start");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      accept && !req_mode |=> state_ff == S_IDLE)
      else $error("load left idle");
   // a pending flag is never overwritten
   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && rsp_stall |=> state_ff == S_DONE)
      else $error("result overwritten");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> step_ff <= MulLast)
      else $error("multiplier step out of range");

endmodule
